FILE: hw/rtl/incoming_probe_tracker_unit_macros.svh
// ----------------------------------------------------------------------------
// Incoming probe tracker assertion macros
// Shared concurrent assertion forms used by the tracker checker.
// ----------------------------------------------------------------------------
`ifndef INCOMING_PROBE_TRACKER_UNIT_MACROS_SVH
`define INCOMING_PROBE_TRACKER_UNIT_MACROS_SVH

// Checked on every clock edge while out of reset
`define IPT_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included
`define IPT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/ipt_pkg.sv
// ----------------------------------------------------------------------------
// Incoming probe tracker package
// Sizes, codes and shared types of the probe tracker.
// ----------------------------------------------------------------------------
package ipt_pkg;

  // Table geometry
  localparam int SLOTS     = 8;
  localparam int IDX_W     = $clog2(SLOTS);
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int MAX_OUT   = 8;
  localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

  // Field widths
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;
  localparam int ID_W    = 16;
  localparam int STAMP_W = 32;

  localparam logic [STAMP_W-1:0] TIMEOUT_RST = 32'd1000;

  typedef enum logic [CMD_W-1:0] {
    CMD_CTRL  = 2'd0,
    CMD_MSG   = 2'd1,
    CMD_SCAN  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SUCCESS       = 2'd0,
    KIND_FAILURE       = 2'd1,
    KIND_PROBE_RESET   = 2'd2,
    KIND_REGULAR_RESET = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_BLANK     = 3'd0,
    ST_WAIT_CTRL = 3'd1,
    ST_WAIT_MSG  = 3'd2,
    ST_SUCCEEDED = 3'd3,
    ST_FAILED    = 3'd4
  } slot_st_t;

  // One slot's payload as held in the slot memory
  typedef struct packed {
    logic [ID_W-1:0]    pid;
    logic [ID_W-1:0]    source;
    logic [STAMP_W-1:0] stamp;
  } slot_entry_t;

  // Slot memory access from the sequencer
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    slot_entry_t       wdata;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  // Operands of the shared compare unit held by the sequencer
  typedef struct packed {
    logic [ID_W-1:0]    pid;
    logic [ID_W-1:0]    source;
    logic [STAMP_W-1:0] now;
    logic [STAMP_W-1:0] timeout;
  } cmp_req_t;

  // Compare unit flags
  typedef struct packed {
    logic id_eq;
    logic src_eq;
    logic due;
  } cmp_res_t;

endpackage

FILE: hw/rtl/ipt_slot_mem.sv
// ----------------------------------------------------------------------------
// Probe tracker slot memory
// One write port and one registered read port holding id, source and stamp.
// ----------------------------------------------------------------------------
module ipt_slot_mem (
  input  logic                 clk,
  input  ipt_pkg::mem_req_t    mem_req,
  output ipt_pkg::slot_entry_t rdata
);
  import ipt_pkg::*;

  slot_entry_t mem [SLOTS];
  slot_entry_t rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    rdata_r <= mem[mem_req.raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/ipt_cmp_unit.sv
// ----------------------------------------------------------------------------
// Probe tracker compare unit
// Shared id / source match and age-versus-timeout check for one slot.
// ----------------------------------------------------------------------------
module ipt_cmp_unit (
  input  ipt_pkg::slot_entry_t entry,
  input  ipt_pkg::cmp_req_t    req,
  output ipt_pkg::cmp_res_t    res
);
  import ipt_pkg::*;

  logic [STAMP_W-1:0] age;

  // Age wraps modulo 2^32
  assign age        = req.now - entry.stamp;
  assign res.id_eq  = (entry.pid == req.pid);
  assign res.src_eq = (entry.source == req.source);
  assign res.due    = (age >= req.timeout);

endmodule

FILE: hw/rtl/ipt_seq.sv
// ----------------------------------------------------------------------------
// Probe tracker sequencer
// Walks the slots one per cycle, holds slot states and drives results.
// ----------------------------------------------------------------------------
module ipt_seq (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ipt_pkg::CMD_W-1:0]    in_cmd,
  input  logic [ipt_pkg::ID_W-1:0]     in_pid,
  input  logic [ipt_pkg::ID_W-1:0]     in_source,
  input  logic [ipt_pkg::STAMP_W-1:0]  in_now,
  input  logic                         cfg_we,
  input  logic [ipt_pkg::STAMP_W-1:0]  cfg_wdata,
  output ipt_pkg::mem_req_t            mem_req,
  input  ipt_pkg::slot_entry_t         rdata,
  output ipt_pkg::cmp_req_t            cmp_req,
  input  ipt_pkg::cmp_res_t            cmp_res,
  output logic                         out_valid,
  output logic [ipt_pkg::KIND_W-1:0]   out_kind,
  output logic [ipt_pkg::ID_W-1:0]     out_result_pid,
  output logic [ipt_pkg::ID_W-1:0]     out_node,
  output logic                         out_last
);
  import ipt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_ALLOC,
    S_FLUSH
  } seq_st_t;

  seq_st_t              state_r, state_nxt;
  slot_st_t             slot_st_r [SLOTS];
  slot_st_t             slot_st_nxt [SLOTS];
  logic [IDX_W-1:0]     ap_r, ap_nxt;
  logic [CNT_W-1:0]     acnt_r, acnt_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic                 ev_vld_r, ev_vld_nxt;
  logic [IDX_W-1:0]     ev_idx_r, ev_idx_nxt;
  logic [OUT_CNT_W-1:0] fcnt_r, fcnt_nxt;
  logic [STAMP_W-1:0]   timeout_r, timeout_nxt;

  // Request held during the walk
  cmd_t                 cmd_r, cmd_nxt;
  logic [ID_W-1:0]      id_r, id_nxt;
  logic [ID_W-1:0]      src_r, src_nxt;
  logic [STAMP_W-1:0]   now_r, now_nxt;

  // Pending failure whose last flag is not known yet
  logic                 pend_vld_r, pend_vld_nxt;
  logic [ID_W-1:0]      pend_id_r, pend_id_nxt;
  logic [ID_W-1:0]      pend_src_r, pend_src_nxt;

  // Result registers
  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, out_kind_nxt;
  logic [ID_W-1:0]      out_id_r, out_id_nxt;
  logic [ID_W-1:0]      out_node_r, out_node_nxt;
  logic                 out_last_r, out_last_nxt;

  // Next-state logic
  always_comb begin
    slot_st_t ev_st;
    slot_st_t own_st;
    slot_st_t ap_st;
    logic     ev_end;

    state_nxt     = state_r;
    slot_st_nxt   = slot_st_r;
    ap_nxt        = ap_r;
    acnt_nxt      = acnt_r;
    idx_nxt       = idx_r;
    ev_vld_nxt    = 1'b0;
    ev_idx_nxt    = ev_idx_r;
    fcnt_nxt      = fcnt_r;
    timeout_nxt   = cfg_we ? cfg_wdata : timeout_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    src_nxt       = src_r;
    now_nxt       = now_r;
    pend_vld_nxt  = pend_vld_r;
    pend_id_nxt   = pend_id_r;
    pend_src_nxt  = pend_src_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_id_nxt    = out_id_r;
    out_node_nxt  = out_node_r;
    out_last_nxt  = out_last_r;

    mem_req.we           = 1'b0;
    mem_req.waddr        = ap_r;
    mem_req.wdata.pid    = id_r;
    mem_req.wdata.source = src_r;
    mem_req.wdata.stamp  = now_r;
    mem_req.raddr        = idx_r[IDX_W-1:0];

    ev_st  = slot_st_r[ev_idx_r];
    own_st = (cmd_r == CMD_CTRL) ? ST_WAIT_CTRL : ST_WAIT_MSG;
    ap_st  = slot_st_r[ap_r];
    ev_end = (ev_idx_r == IDX_W'(SLOTS - 1));

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt      = cmd_t'(in_cmd);
          id_nxt       = in_pid;
          src_nxt      = in_source;
          now_nxt      = in_now;
          idx_nxt      = '0;
          acnt_nxt     = '0;
          fcnt_nxt     = '0;
          pend_vld_nxt = 1'b0;
          state_nxt    = S_SWEEP;
        end
      end

      S_SWEEP: begin
        // Issue the next slot read
        if (idx_r < CNT_W'(SLOTS)) begin
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = idx_r[IDX_W-1:0];
          idx_nxt    = idx_r + 1'b1;
        end
        // Evaluate the slot read last cycle
        if (ev_vld_r) begin
          case (cmd_r)
            CMD_CTRL, CMD_MSG: begin
              if (ev_st != ST_BLANK && cmp_res.id_eq) begin
                if (ev_st == own_st && cmp_res.src_eq) begin
                  slot_st_nxt[ev_idx_r] = ST_SUCCEEDED;
                  out_valid_nxt         = 1'b1;
                  out_kind_nxt          = KIND_SUCCESS;
                  out_id_nxt            = id_r;
                  out_node_nxt          = src_r;
                  out_last_nxt          = 1'b1;
                end
                state_nxt = S_IDLE;
              end else if (ev_end) begin
                state_nxt = S_ALLOC;
              end
            end

            CMD_SCAN: begin
              if ((ev_st inside {ST_WAIT_CTRL, ST_WAIT_MSG}) && cmp_res.due &&
                  fcnt_r < OUT_CNT_W'(MAX_OUT)) begin
                slot_st_nxt[ev_idx_r] = ST_FAILED;
                fcnt_nxt              = fcnt_r + 1'b1;
                // Older failure is now known not to be the last
                if (pend_vld_r) begin
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = KIND_FAILURE;
                  out_id_nxt    = pend_id_r;
                  out_node_nxt  = pend_src_r;
                  out_last_nxt  = 1'b0;
                end
                pend_vld_nxt = 1'b1;
                pend_id_nxt  = rdata.pid;
                pend_src_nxt = rdata.source;
              end
              if (ev_end) begin
                state_nxt = S_FLUSH;
              end
            end

            CMD_QUERY: begin
              if (ev_st == ST_WAIT_MSG && cmp_res.src_eq) begin
                out_valid_nxt = 1'b1;
                out_node_nxt  = src_r;
                out_last_nxt  = 1'b1;
                if (rdata.pid != '0) begin
                  out_kind_nxt = KIND_PROBE_RESET;
                  out_id_nxt   = rdata.pid;
                end else begin
                  out_kind_nxt = KIND_REGULAR_RESET;
                  out_id_nxt   = '0;
                end
                state_nxt = S_IDLE;
              end else if (ev_end) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_REGULAR_RESET;
                out_id_nxt    = '0;
                out_node_nxt  = src_r;
                out_last_nxt  = 1'b1;
                state_nxt     = S_IDLE;
              end
            end

            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_ALLOC: begin
        // Round-robin walk for a free slot
        ap_nxt   = (ap_r == IDX_W'(SLOTS - 1)) ? '0 : ap_r + 1'b1;
        acnt_nxt = acnt_r + 1'b1;
        if (ap_st inside {ST_BLANK, ST_SUCCEEDED, ST_FAILED}) begin
          slot_st_nxt[ap_r] = (cmd_r == CMD_CTRL) ? ST_WAIT_MSG : ST_WAIT_CTRL;
          mem_req.we        = 1'b1;
          state_nxt         = S_IDLE;
        end else if (acnt_r == CNT_W'(SLOTS - 1)) begin
          // Table full: drop
          state_nxt = S_IDLE;
        end
      end

      S_FLUSH: begin
        if (pend_vld_r) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = KIND_FAILURE;
          out_id_nxt    = pend_id_r;
          out_node_nxt  = pend_src_r;
          out_last_nxt  = 1'b1;
        end
        pend_vld_nxt = 1'b0;
        state_nxt    = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      for (int i = 0; i < SLOTS; i++) begin
        slot_st_r[i] <= ST_BLANK;
      end
      ap_r        <= '0;
      ev_vld_r    <= 1'b0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
    end else begin
      state_r     <= state_nxt;
      slot_st_r   <= slot_st_nxt;
      ap_r        <= ap_nxt;
      ev_vld_r    <= ev_vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
      timeout_r   <= timeout_nxt;
    end
    acnt_r     <= acnt_nxt;
    idx_r      <= idx_nxt;
    ev_idx_r   <= ev_idx_nxt;
    fcnt_r     <= fcnt_nxt;
    cmd_r      <= cmd_nxt;
    id_r       <= id_nxt;
    src_r      <= src_nxt;
    now_r      <= now_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_src_r <= pend_src_nxt;
    out_kind_r <= out_kind_nxt;
    out_id_r   <= out_id_nxt;
    out_node_r <= out_node_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign cmp_req.pid     = id_r;
  assign cmp_req.source  = src_r;
  assign cmp_req.now     = now_r;
  assign cmp_req.timeout = timeout_r;
  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_result_pid  = out_id_r;
  assign out_node        = out_node_r;
  assign out_last        = out_last_r;

endmodule

FILE: hw/rtl/incoming_probe_tracker_unit.sv
// ----------------------------------------------------------------------------
// Incoming probe tracker
// Slot table that pairs control and message packets of network probes,
// fails stale probes on a scan and answers residual-switching queries.
// ----------------------------------------------------------------------------
//
//  channel  handshake         payload
//  -------  ----------------  ------------------------------------------------
//  in       start / busy      in_cmd, in_pid, in_source, in_now
//  out      out_valid strobe  out_kind, out_result_pid, out_node, out_last
//  cfg      cfg_we            cfg_wdata (timeout_ticks)
//
// A request walks the slot table one slot per cycle through the single read
// port of the slot memory and the shared compare unit. A scan ends with a
// flush of its last failure, a control or message request with no id match
// walks round-robin for a free slot, and a hit ends the walk early.
// Synchronous reset clears all slots to blank, the allocation pointer to zero
// and timeout_ticks to 1000. The receiver cannot stall: each result is
// presented for one cycle only.
module incoming_probe_tracker_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ipt_pkg::CMD_W-1:0]    in_cmd,
  input  logic [ipt_pkg::ID_W-1:0]     in_pid,
  input  logic [ipt_pkg::ID_W-1:0]     in_source,
  input  logic [ipt_pkg::STAMP_W-1:0]  in_now,
  output logic                         out_valid,
  output logic [ipt_pkg::KIND_W-1:0]   out_kind,
  output logic [ipt_pkg::ID_W-1:0]     out_result_pid,
  output logic [ipt_pkg::ID_W-1:0]     out_node,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [ipt_pkg::STAMP_W-1:0]  cfg_wdata
);
  import ipt_pkg::*;

  mem_req_t    mem_req;
  slot_entry_t rdata;
  cmp_req_t    cmp_req;
  cmp_res_t    cmp_res;

  // Slot payload storage
  ipt_slot_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (rdata)
  );

  // Shared compare
  ipt_cmp_unit u_cmp (
    .entry (rdata),
    .req   (cmp_req),
    .res   (cmp_res)
  );

  // Sequencer
  ipt_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_pid         (in_pid),
    .in_source      (in_source),
    .in_now         (in_now),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .mem_req        (mem_req),
    .rdata          (rdata),
    .cmp_req        (cmp_req),
    .cmp_res        (cmp_res),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_result_pid (out_result_pid),
    .out_node       (out_node),
    .out_last       (out_last)
  );

endmodule

FILE: hw/rtl/ipt_checker.sv
// ----------------------------------------------------------------------------
// Probe tracker port checker
// Port-level assertions, bound to the tracker top level.
// ----------------------------------------------------------------------------
`include "incoming_probe_tracker_unit_macros.svh"

module ipt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic [ipt_pkg::KIND_W-1:0]   out_kind,
  input logic [ipt_pkg::ID_W-1:0]     out_result_pid,
  input logic                         out_last
);
  import ipt_pkg::*;

  logic reg_rst_v;
  logic prb_rst_v;

  // Reset result kinds on the strobe
  assign reg_rst_v = out_valid && (out_kind == KIND_REGULAR_RESET);
  assign prb_rst_v = out_valid && (out_kind == KIND_PROBE_RESET);

  // Reset leaves the block idle with no result
  `IPT_ASSERT_RST(a_rst_idle, !rst_n |=> (!busy && !out_valid), "not idle after reset")

  // An accepted request keeps the block busy
  `IPT_ASSERT_CLK(a_accept_busy, (start && !busy) |=> busy, "request accepted but not busy")

  // More results follow a non-final one
  `IPT_ASSERT_CLK(a_more_busy, (out_valid && !out_last) |-> busy, "non-final result while idle")

  // Regular-packet reset carries id zero
  `IPT_ASSERT_CLK(a_reg_id, reg_rst_v |-> (out_result_pid == '0), "regular reset id not zero")

  // Probe reset carries a nonzero id
  `IPT_ASSERT_CLK(a_probe_id, prb_rst_v |-> (out_result_pid != '0), "probe reset with zero id")

endmodule

bind incoming_probe_tracker_unit ipt_checker u_ipt_checker (.*);
